// File: design/idll_pkg.sv
package idll_pkg;

	typedef logic signed [10:0] link_t;

	localparam int IDLL_NODES = 1024;
	localparam link_t LINK_NULL = 11'sh7FF;

	localparam logic [2:0] CMD_LOAD       = 3'd0;
	localparam logic [2:0] CMD_RESTART    = 3'd1;
	localparam logic [2:0] CMD_INS_BEFORE = 3'd2;
	localparam logic [2:0] CMD_INS_AFTER  = 3'd3;
	localparam logic [2:0] CMD_REMOVE     = 3'd4;
	localparam logic [2:0] CMD_READ       = 3'd5;

	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_NULL = 2'd2;

	localparam logic [1:0] REG_HEAD  = 2'd0;
	localparam logic [1:0] REG_TAIL  = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	typedef struct packed {
		link_t       head;
		link_t       tail;
		logic [10:0] count;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic exec;
		logic step2;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic two_step;
	} dp_stat_t;

endpackage

// File: design/idll_regs.sv
module idll_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output idll_pkg::cfg_t    cfg
);
	import idll_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.head  <= LINK_NULL;
			cfg_q.tail  <= LINK_NULL;
			cfg_q.count <= '0;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_HEAD:  cfg_q.head  <= link_t'(pwdata[10:0]);
				REG_TAIL:  cfg_q.tail  <= link_t'(pwdata[10:0]);
				REG_COUNT: cfg_q.count <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_HEAD:  prdata = 32'(cfg_q.head);
			REG_TAIL:  prdata = 32'(cfg_q.tail);
			REG_COUNT: prdata = 32'(cfg_q.count);
			default:   prdata = '0;
		endcase
	end

endmodule

// File: design/idll_ctrl.sv
module idll_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  idll_pkg::dp_stat_t    stat,
	output idll_pkg::ctrl_cmd_t   ctl
);
	import idll_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_EXEC  = 3'b010,
		S_STEP2 = 3'b100
	} state_t;

	state_t state_q, state_d;

	assign busy       = (state_q != S_IDLE);
	assign ctl.accept = start && (state_q == S_IDLE);
	assign ctl.exec   = (state_q == S_EXEC);
	assign ctl.step2  = (state_q == S_STEP2);
	assign ctl.finish = (ctl.exec && !stat.two_step) || ctl.step2;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (start) state_d = S_EXEC;
			S_EXEC:  state_d = stat.two_step ? S_STEP2 : S_IDLE;
			S_STEP2: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == S_IDLE) |=> state_q == S_EXEC)
		else $error("accepted command did not enter execute");

	a_step2_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP2) |=> state_q == S_IDLE)
		else $error("second link write step did not return to idle");

	a_single_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && !stat.two_step) |=> state_q == S_IDLE)
		else $error("single-step command did not return to idle");

endmodule

// File: design/idll_dp.sv
module idll_dp #(
	parameter int NODES = idll_pkg::IDLL_NODES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  idll_pkg::ctrl_cmd_t   ctl,
	output idll_pkg::dp_stat_t    stat,
	input  idll_pkg::cfg_t        cfg,
	input  logic [2:0]            cmd,
	input  logic signed [10:0]    node_index,
	input  logic signed [31:0]    value,
	input  logic signed [10:0]    link_next,
	input  logic signed [10:0]    link_prev,
	output logic                  done,
	output logic [1:0]            status,
	output logic signed [31:0]    result_value,
	output logic signed [10:0]    node_next,
	output logic signed [10:0]    node_prev,
	output logic signed [10:0]    list_head,
	output logic signed [10:0]    list_tail
);
	import idll_pkg::*;

	localparam int AW = $clog2(NODES);

	// index modulo store depth; plain truncation when the depth is a power of two
	function automatic logic [AW-1:0] slot_of(input logic [10:0] v);
		logic [AW:0] r;
		r = '0;
		if (NODES >= 2048) begin
			r = (AW+1)'(v);
		end else begin
			for (int i = 10; i >= 0; i--) begin
				r = {r[AW-1:0], v[i]};
				if (r >= (AW+1)'(NODES)) r = r - (AW+1)'(NODES);
			end
		end
		return r[AW-1:0];
	endfunction

	logic signed [31:0] mem_data [NODES];
	link_t              mem_next [NODES];
	link_t              mem_prev [NODES];

	logic signed [31:0] rd_data_q;
	link_t              rd_next_q, rd_prev_q;

	logic [2:0]         cmd_q;
	link_t              idx_q, lnx_q, lpv_q;
	logic signed [31:0] val_q;

	link_t              head_q, tail_q;
	logic [10:0]        free_q;
	logic               done_q;
	logic               w2n_en_q, w2p_en_q;
	logic [AW-1:0]      w2n_addr_q, w2p_addr_q;
	link_t              lnk_q;

	logic [1:0]         status_q;
	logic signed [31:0] rval_q;
	link_t              rnext_q, rprev_q;

	// next-state / write-port signals
	logic               we_data, we_next, we_prev;
	logic [AW-1:0]      wa_data, wa_next, wa_prev;
	logic signed [31:0] wd_data;
	link_t              wd_next, wd_prev;
	link_t              head_d, tail_d;
	logic [10:0]        free_d;
	logic [1:0]         status_d;
	logic signed [31:0] rval_d;
	link_t              rnext_d, rprev_d;
	logic               w2n_en_d, w2p_en_d;
	logic [AW-1:0]      w2n_addr_d, w2p_addr_d;

	logic               is_ins, full;
	logic [AW-1:0]      s_addr, nw_addr;
	link_t              lnk, pn, nn;

	assign is_ins   = (cmd_q == CMD_INS_BEFORE) || (cmd_q == CMD_INS_AFTER);
	assign full     = int'(free_q) >= NODES;
	assign s_addr   = slot_of(idx_q);
	assign nw_addr  = slot_of(free_q);
	assign lnk      = $signed(free_q);
	// neighbor link as the store stands after the new node's own links are written
	assign pn       = (s_addr == nw_addr) ? lnk : rd_prev_q;
	assign nn       = (s_addr == nw_addr) ? lnk : rd_next_q;

	assign stat.two_step = is_ins && !full;

	always_comb begin
		we_data    = 1'b0;
		we_next    = 1'b0;
		we_prev    = 1'b0;
		wa_data    = nw_addr;
		wa_next    = nw_addr;
		wa_prev    = nw_addr;
		wd_data    = val_q;
		wd_next    = LINK_NULL;
		wd_prev    = LINK_NULL;
		head_d     = head_q;
		tail_d     = tail_q;
		free_d     = free_q;
		status_d   = STAT_OK;
		rval_d     = '0;
		rnext_d    = '0;
		rprev_d    = '0;
		w2n_en_d   = 1'b0;
		w2p_en_d   = 1'b0;
		w2n_addr_d = s_addr;
		w2p_addr_d = s_addr;

		if (ctl.step2) begin
			we_next = w2n_en_q;
			wa_next = w2n_addr_q;
			wd_next = lnk_q;
			we_prev = w2p_en_q;
			wa_prev = w2p_addr_q;
			wd_prev = lnk_q;
		end else if (ctl.exec) begin
			unique case (cmd_q)
				CMD_LOAD: begin
					if (idx_q[10]) begin
						status_d = STAT_NULL;
					end else begin
						we_data = 1'b1;
						we_next = 1'b1;
						we_prev = 1'b1;
						wa_data = s_addr;
						wa_next = s_addr;
						wa_prev = s_addr;
						wd_next = lnx_q;
						wd_prev = lpv_q;
					end
				end
				CMD_RESTART: begin
					head_d = cfg.head;
					tail_d = cfg.tail;
					free_d = cfg.count;
				end
				CMD_READ, CMD_REMOVE: begin
					if (idx_q[10]) begin
						status_d = STAT_NULL;
					end else begin
						rval_d  = rd_data_q;
						rnext_d = rd_next_q;
						rprev_d = rd_prev_q;
						if (cmd_q == CMD_REMOVE) begin
							if (!rd_prev_q[10]) begin
								we_next = 1'b1;
								wa_next = slot_of(rd_prev_q);
								wd_next = rd_next_q;
							end else begin
								head_d = rd_next_q;
							end
							if (!rd_next_q[10]) begin
								we_prev = 1'b1;
								wa_prev = slot_of(rd_next_q);
								wd_prev = rd_prev_q;
							end else begin
								tail_d = rd_prev_q;
							end
						end
					end
				end
				CMD_INS_BEFORE, CMD_INS_AFTER: begin
					if (full) begin
						status_d = STAT_FULL;
					end else begin
						free_d  = free_q + 11'd1;
						rval_d  = 32'(free_q);
						we_data = 1'b1;
						we_next = 1'b1;
						we_prev = 1'b1;
						if (cmd_q == CMD_INS_BEFORE) begin
							if (idx_q[10]) begin
								wd_prev    = tail_q;
								wd_next    = LINK_NULL;
								w2n_en_d   = !tail_q[10];
								w2n_addr_d = slot_of(tail_q);
								tail_d     = lnk;
								if (head_q[10]) head_d = lnk;
							end else begin
								wd_prev    = rd_prev_q;
								wd_next    = idx_q;
								w2p_en_d   = 1'b1;
								w2p_addr_d = s_addr;
								w2n_en_d   = !pn[10];
								w2n_addr_d = slot_of(pn);
								if (pn[10]) head_d = lnk;
							end
						end else begin
							if (idx_q[10]) begin
								wd_prev    = LINK_NULL;
								wd_next    = head_q;
								w2p_en_d   = !head_q[10];
								w2p_addr_d = slot_of(head_q);
								head_d     = lnk;
								if (tail_q[10]) tail_d = lnk;
							end else begin
								wd_prev    = idx_q;
								wd_next    = rd_next_q;
								w2n_en_d   = 1'b1;
								w2n_addr_d = s_addr;
								w2p_en_d   = !nn[10];
								w2p_addr_d = slot_of(nn);
								if (nn[10]) tail_d = lnk;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	// node store
	always_ff @(posedge clk) begin
		if (we_data) mem_data[wa_data] <= wd_data;
		if (we_next) mem_next[wa_next] <= wd_next;
		if (we_prev) mem_prev[wa_prev] <= wd_prev;
	end

	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			rd_data_q <= mem_data[slot_of(node_index)];
			rd_next_q <= mem_next[slot_of(node_index)];
			rd_prev_q <= mem_prev[slot_of(node_index)];
		end
	end

	// command capture and result payload
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			cmd_q <= cmd;
			idx_q <= node_index;
			val_q <= value;
			lnx_q <= link_next;
			lpv_q <= link_prev;
		end
		if (ctl.exec) begin
			status_q   <= status_d;
			rval_q     <= rval_d;
			rnext_q    <= rnext_d;
			rprev_q    <= rprev_d;
			w2n_addr_q <= w2n_addr_d;
			w2p_addr_q <= w2p_addr_d;
			lnk_q      <= lnk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= LINK_NULL;
			tail_q   <= LINK_NULL;
			free_q   <= '0;
			done_q   <= 1'b0;
			w2n_en_q <= 1'b0;
			w2p_en_q <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			free_q <= free_d;
			done_q <= ctl.finish;
			if (ctl.exec) begin
				w2n_en_q <= w2n_en_d;
				w2p_en_q <= w2p_en_d;
			end
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign result_value = rval_q;
	assign node_next    = rnext_q;
	assign node_prev    = rprev_q;
	assign list_head    = head_q;
	assign list_tail    = tail_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");

	a_free_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.exec |=> $stable(free_q))
		else $error("allocator moved outside command execution");

endmodule

// File: design/indexed_doubly_linked_list_core.sv
// Channel   | Handshake                         | Payload
// ----------+-----------------------------------+--------------------------------------------
// command   | start in, busy out (start & !busy) | cmd, node_index, value, link_next, link_prev
// result    | done out, one-cycle strobe         | status, result_value, node_next, node_prev,
//           |                                   | list_head, list_tail
// config    | APB psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// An insert with room reads, writes the new node, then patches the neighbors in a second step;
// other commands end after the first. The single write port of each link memory sets this.
// A new command can be transferred in the cycle its predecessor's result is strobed.
// The result receiver cannot stall; each result is valid only during its done cycle.
// Reset empties the list (head and tail null, allocator at zero); node storage is not cleared.
module indexed_doubly_linked_list_core #(
	parameter int NODES = idll_pkg::IDLL_NODES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          cmd,
	input  logic signed [10:0]  node_index,
	input  logic signed [31:0]  value,
	input  logic signed [10:0]  link_next,
	input  logic signed [10:0]  link_prev,
	output logic                done,
	output logic [1:0]          status,
	output logic signed [31:0]  result_value,
	output logic signed [10:0]  node_next,
	output logic signed [10:0]  node_prev,
	output logic signed [10:0]  list_head,
	output logic signed [10:0]  list_tail,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import idll_pkg::*;

	cfg_t      cfg;
	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	idll_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	idll_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.ctl    (ctl)
	);

	idll_dp #(
		.NODES (NODES)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.cfg          (cfg),
		.cmd          (cmd),
		.node_index   (node_index),
		.value        (value),
		.link_next    (link_next),
		.link_prev    (link_prev),
		.done         (done),
		.status       (status),
		.result_value (result_value),
		.node_next    (node_next),
		.node_prev    (node_prev),
		.list_head    (list_head),
		.list_tail    (list_tail)
	);

endmodule
